>>> rtl/longest_axis_midpoint_partition_macros.svh
// assertion macros
`ifndef LONGEST_AXIS_MIDPOINT_PARTITION_MACROS_SVH
`define LONGEST_AXIS_MIDPOINT_PARTITION_MACROS_SVH
`define LAMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LAMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/lamp_pkg.sv
`default_nettype none
package lamp_pkg;
  localparam int MaxPoints = 64;
  localparam int CoordBits = 24;
  localparam int IdxBits = $clog2(MaxPoints);
  localparam int CntBits = $clog2(MaxPoints + 1);
  localparam int QDepth = 2;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x_coord;
    coord_t y_coord;
    coord_t z_coord;
    logic last_point;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] orig_index;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic [6:0] split_position;
    logic [1:0] split_axis;
    logic degenerate;
    logic overflow;
    logic last_result;
  } out_beat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic last;
    logic keep;
  } cmd_t;
endpackage
`default_nettype wire

>>> rtl/lamp_front.sv
`default_nettype none
module lamp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lamp_pkg::in_beat_t in_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output lamp_pkg::cmd_t         cmd_o,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i
);
  localparam int PtrBits = $clog2(lamp_pkg::QDepth);
  lamp_pkg::cmd_t q_mem [lamp_pkg::QDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0] fill_q;
  logic [lamp_pkg::CntBits-1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (fill_q != (PtrBits+1)'(lamp_pkg::QDepth));
  assign push = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != '0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= '{x: in_data_i.x_coord, y: in_data_i.y_coord, z: in_data_i.z_coord,
                       last: in_data_i.last_point,
                       keep: (cnt_q != lamp_pkg::CntBits'(lamp_pkg::MaxPoints))};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      fill_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
        if (in_data_i.last_point) cnt_q <= '0;
        else if (cnt_q != lamp_pkg::CntBits'(lamp_pkg::MaxPoints)) cnt_q <= cnt_q + 1'b1;
      end
      if (pop) rd_q <= rd_q + 1'b1;
      fill_q <= fill_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/lamp_back.sv
`default_nettype none
`include "longest_axis_midpoint_partition_macros.svh"
module lamp_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lamp_pkg::cmd_t     cmd_i,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  output lamp_pkg::out_beat_t     out_data_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i
);
  localparam int IB = lamp_pkg::IdxBits;
  localparam int CB = lamp_pkg::CntBits;
  localparam int W = lamp_pkg::CoordBits;
  localparam int EntW = 3 * W + 6;
  localparam logic [2:0] S_LOAD = 3'd0, S_SCANLO = 3'd1, S_SCANHI = 3'd2,
                         S_SWAPA = 3'd3, S_SWAPB = 3'd4, S_EMIT = 3'd5, S_WAIT = 3'd6;

  logic [EntW-1:0] mem [lamp_pkg::MaxPoints];
  logic [EntW-1:0] rd_q, hold_q;
  logic [2:0] st_q;
  logic [CB-1:0] cnt_q, lo_q, hi_q, em_q;
  logic hi_neg_q, ovf_q, degen_q, rd_ok_q;
  logic [1:0] axis_q;
  lamp_pkg::coord_t mn_q [3], mx_q [3];
  logic signed [W:0] sum_q;
  logic [IB-1:0] raddr;
  logic we;
  logic [IB-1:0] waddr;
  logic [EntW-1:0] wdata;
  logic accept, fire;
  lamp_pkg::coord_t pc [3];
  logic signed [W:0] dx, dy, dz, twop;
  lamp_pkg::coord_t rc;
  logic lower;

  assign pc[0] = cmd_i.x;
  assign pc[1] = cmd_i.y;
  assign pc[2] = cmd_i.z;
  assign cmd_ready_o = (st_q == S_LOAD);
  assign accept = cmd_valid_i && cmd_ready_o;
  assign fire = out_valid_o && out_ready_i;

  always_comb begin
    dx = (W+1)'(mx_q[0]) - (W+1)'(mn_q[0]);
    dy = (W+1)'(mx_q[1]) - (W+1)'(mn_q[1]);
    dz = (W+1)'(mx_q[2]) - (W+1)'(mn_q[2]);
    case (axis_q)
      2'd0: rc = rd_q[EntW-1 -: W];
      2'd1: rc = rd_q[EntW-1-W -: W];
      default: rc = rd_q[EntW-1-2*W -: W];
    endcase
    twop = {rc, 1'b0};
    lower = (twop < sum_q);
  end

  always_comb begin
    raddr = em_q[IB-1:0];
    case (st_q)
      S_SCANLO: raddr = lo_q[IB-1:0];
      S_SCANHI: raddr = hi_q[IB-1:0];
      S_SWAPA: raddr = lo_q[IB-1:0];
      default: raddr = em_q[IB-1:0];
    endcase
    we = 1'b0;
    waddr = cnt_q[IB-1:0];
    wdata = {cmd_i.x, cmd_i.y, cmd_i.z, cnt_q[5:0]};
    if (accept && cmd_i.keep) we = 1'b1;
    if (st_q == S_SWAPA) begin
      we = 1'b1;
      waddr = lo_q[IB-1:0];
      wdata = rd_q;
    end
    if (st_q == S_SWAPB) begin
      we = 1'b1;
      waddr = hi_q[IB-1:0];
      wdata = hold_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      lo_q <= '0;
      hi_q <= '0;
      em_q <= '0;
      hi_neg_q <= 1'b0;
      degen_q <= 1'b0;
      axis_q <= '0;
      rd_ok_q <= 1'b0;
      sum_q <= '0;
      hold_q <= '0;
      out_valid_o <= 1'b0;
      out_data_o <= '0;
      for (int a = 0; a < 3; a++) begin
        mn_q[a] <= '0;
        mx_q[a] <= '0;
      end
    end else begin
      rd_ok_q <= 1'b0;
      case (st_q)
        S_LOAD: begin
          if (accept) begin
            if (cmd_i.keep) begin
              for (int a = 0; a < 3; a++) begin
                if (cnt_q == '0 || pc[a] < mn_q[a]) mn_q[a] <= pc[a];
                if (cnt_q == '0 || pc[a] > mx_q[a]) mx_q[a] <= pc[a];
              end
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (cmd_i.last) st_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          lo_q <= '0;
          hi_q <= cnt_q - 1'b1;
          hi_neg_q <= 1'b0;
          em_q <= '0;
          if (dx == '0 && dy == '0 && dz == '0) begin
            degen_q <= 1'b1;
            axis_q <= 2'd0;
            lo_q <= cnt_q >> 1;
            st_q <= S_EMIT;
          end else begin
            degen_q <= 1'b0;
            if (dx > dy) begin
              axis_q <= (dx > dz) ? 2'd0 : 2'd2;
              sum_q <= (dx > dz) ? (W+1)'(mn_q[0]) + (W+1)'(mx_q[0])
                                 : (W+1)'(mn_q[2]) + (W+1)'(mx_q[2]);
            end else begin
              axis_q <= (dy > dz) ? 2'd1 : 2'd2;
              sum_q <= (dy > dz) ? (W+1)'(mn_q[1]) + (W+1)'(mx_q[1])
                                 : (W+1)'(mn_q[2]) + (W+1)'(mx_q[2]);
            end
            st_q <= S_SCANLO;
          end
        end
        S_SCANLO: begin
          if (lo_q == cnt_q) st_q <= S_SCANHI;
          else if (rd_ok_q) begin
            if (lower) lo_q <= lo_q + 1'b1;
            else begin
              hold_q <= rd_q;
              st_q <= S_SCANHI;
            end
          end else rd_ok_q <= 1'b1;
        end
        S_SCANHI: begin
          if (hi_neg_q || hi_q < lo_q) begin
            st_q <= S_EMIT;
          end else if (rd_ok_q) begin
            if (!lower) begin
              if (hi_q == '0) hi_neg_q <= 1'b1;
              hi_q <= hi_q - 1'b1;
            end else st_q <= S_SWAPA;
          end else rd_ok_q <= 1'b1;
        end
        S_SWAPA: st_q <= S_SWAPB;
        S_SWAPB: begin
          st_q <= S_SCANLO;
          lo_q <= lo_q + 1'b1;
          if (hi_q == '0) hi_neg_q <= 1'b1;
          hi_q <= hi_q - 1'b1;
        end
        S_EMIT: begin
          if (fire) out_valid_o <= 1'b0;
          if (em_q == cnt_q && (fire || !out_valid_o)) begin
            st_q <= S_LOAD;
            cnt_q <= '0;
            ovf_q <= 1'b0;
            for (int a = 0; a < 3; a++) begin
              mn_q[a] <= '0;
              mx_q[a] <= '0;
            end
          end else if (rd_ok_q && (fire || !out_valid_o)) begin
            out_valid_o <= 1'b1;
            out_data_o <= '{orig_index: rd_q[5:0], out_x: rd_q[EntW-1 -: W],
                            out_y: rd_q[EntW-1-W -: W], out_z: rd_q[EntW-1-2*W -: W],
                            split_position: 7'(lo_q), split_axis: axis_q,
                            degenerate: degen_q, overflow: ovf_q,
                            last_result: (em_q == cnt_q - 1'b1)};
            em_q <= em_q + 1'b1;
          end else if (!rd_ok_q && em_q != cnt_q && (fire || !out_valid_o)) begin
            rd_ok_q <= 1'b1;
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

  `LAMP_ASSERT_IMPL(a_no_load_busy, clk_i, rst_ni, st_q != S_LOAD, !cmd_ready_o, "load while busy")
  `LAMP_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CB'(lamp_pkg::MaxPoints), "count over")
  `LAMP_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "out dropped")
endmodule
`default_nettype wire

>>> rtl/longest_axis_midpoint_partition.sv
`default_nettype none
// Loads up to 64 signed 3D points (one beat each, one beat per cycle while in_ready_o
// is high), then after the beat carrying last_point splits them at the midpoint of the
// longest box axis with a two-pointer in-place partition over a one-read one-write point
// memory (coincident points skip it and are flagged degenerate), and drains every stored
// point in its new order. A short queue in front takes beats during these, until full.
module longest_axis_midpoint_partition (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lamp_pkg::in_beat_t  in_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output lamp_pkg::out_beat_t      out_data_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i
);
  lamp_pkg::cmd_t cmd;
  logic cmd_valid, cmd_ready;

  lamp_front u_front (.clk_i, .rst_ni, .in_data_i, .in_valid_i, .in_ready_o,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready));
  lamp_back u_back (.clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready), .out_data_o, .out_valid_o, .out_ready_i);
endmodule
`default_nettype wire
